// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/tbo_pkg.sv =====
package tbo_pkg;
  localparam logic [1:0] OP_C2P = 2'd0;
  localparam logic [1:0] OP_P2C = 2'd1;
  localparam logic [1:0] OP_INC = 2'd2;
  localparam logic [1:0] OP_DEC = 2'd3;
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;
  localparam int POS_W = 32;

  // Data handed from one cell to the next
  typedef struct packed {
    logic             vld;
    logic [1:0]       op;
    logic             err;
    logic [15:0]      nx;
    logic [15:0]      ny;
    logic [15:0]      cx;
    logic [15:0]      cy;
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] rem;
    logic [17:0]      quo;
    logic [15:0]      by;
    logic [15:0]      bx;
    logic [2:0]       sy;
    logic [2:0]       sx;
    logic [1:0]       ly;
    logic [1:0]       lx;
    logic             at_end;
  } tbo_beat_t;
endpackage

// ===== rtl/tiled_2d_block_order_index.sv =====
// Maps coordinates and positions of a 4x4 block-tiled traversal, one item per cycle
// sustained. Two front stages form the position, a chain of 16 division cells finds
// the row, one stage fixes up the block row, a chain of 18 division cells splits the
// row remainder, and a final stage registers the result. Stall freezes the whole
// chain.
module tiled_2d_block_order_index #(
  parameter int MAX_EXTENT = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_coord_x,
  input  logic [15:0] in_coord_y,
  input  logic [31:0] in_position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_x,
  output logic [15:0] out_y,
  output logic [31:0] out_position,
  output logic        out_range_error
);
  import tbo_pkg::*;
  localparam logic [15:0] MAXE = (MAX_EXTENT > 65535) ? 16'hFFFF : 16'(MAX_EXTENT);
  logic [15:0] w_r, h_r, nx, ny;
  logic adv;
  assign cfg_ready = 1'b1;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;
  // Hold the registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin w_r <= 16'd1; h_r <= 16'd1; end
    else if (cfg_valid) begin
      if (cfg_index == CFG_WIDTH) w_r <= cfg_data;
      else h_r <= cfg_data;
    end
  end
  always_comb begin
    nx = (w_r == 16'd0) ? 16'd1 : ((w_r > MAXE) ? MAXE : w_r);
    ny = (h_r == 16'd0) ? 16'd1 : ((h_r > MAXE) ? MAXE : h_r);
  end

  function automatic logic [2:0] span(input logic [15:0] b, input logic [15:0] n);
    logic [16:0] t;
    begin
      t = {1'b0, b} + 17'd4;
      span = (t > {1'b0, n}) ? 3'(n - b) : 3'd4;
    end
  endfunction

  // Stage 1: check coordinates, form block spans
  tbo_beat_t s1_r, s1_nxt;
  logic [31:0] total;
  always_comb begin
    s1_nxt = '0;
    s1_nxt.vld = in_valid;
    s1_nxt.op = in_operation; s1_nxt.nx = nx; s1_nxt.ny = ny;
    s1_nxt.cx = in_coord_x; s1_nxt.cy = in_coord_y; s1_nxt.p = in_position;
    s1_nxt.by = {in_coord_y[15:2], 2'b00};
    s1_nxt.bx = {in_coord_x[15:2], 2'b00};
    s1_nxt.ly = in_coord_y[1:0]; s1_nxt.lx = in_coord_x[1:0];
    s1_nxt.sy = span(s1_nxt.by, ny); s1_nxt.sx = span(s1_nxt.bx, nx);
    s1_nxt.at_end = (in_coord_y == ny);
    if (in_operation != OP_P2C)
      s1_nxt.err = !((in_coord_y < ny && in_coord_x < nx) ||
                     (in_coord_y == ny && in_coord_x == 16'd0));
  end
  // Stage 2: products by*nx, bx*sy, ly*sx
  tbo_beat_t s2_r, s2_nxt;
  logic [31:0] m_a, m_b, m_c;
  logic [31:0] m_a_r, m_b_r, m_c_r;
  always_comb begin
    s2_nxt = s1_r;
    total = 32'(s1_r.nx) * 32'(s1_r.ny);
    m_a = 32'(s1_r.by) * 32'(s1_r.nx);
    m_b = 32'(s1_r.bx) * 32'(s1_r.sy);
    m_c = 32'(s1_r.ly) * 32'(s1_r.sx) + 32'(s1_r.lx);
    if (s1_r.at_end) begin m_a = total; m_b = '0; m_c = '0; end
  end
  logic [31:0] total_r;
  // Stage 3: position, increment/decrement, error
  tbo_beat_t s3_nxt;
  logic [31:0] pc;
  always_comb begin
    s3_nxt = s2_r;
    pc = m_a_r + m_b_r + m_c_r;
    case (s2_r.op)
      OP_P2C: begin
        if (s2_r.p > total_r) s3_nxt.err = 1'b1;
      end
      OP_INC: begin
        if (pc == total_r) s3_nxt.err = 1'b1;
        s3_nxt.p = pc + 32'd1;
      end
      OP_DEC: begin
        if (pc == 32'd0) s3_nxt.err = 1'b1;
        s3_nxt.p = pc - 32'd1;
      end
      default: s3_nxt.p = pc;
    endcase
    s3_nxt.at_end = (s3_nxt.p == total_r);
    s3_nxt.rem = s3_nxt.p;
    s3_nxt.quo = '0;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin s1_r.vld <= 1'b0; s2_r.vld <= 1'b0; end
    else if (adv) begin s1_r <= s1_nxt; s2_r <= s2_nxt; end
    if (adv) begin
      m_a_r <= m_a; m_b_r <= m_b; m_c_r <= m_c; total_r <= total;
    end
  end

  // Row division chain: p / nx, quotient below 2^16
  tbo_beat_t row_c [17];
  assign row_c[0] = s3_nxt;
  for (genvar k = 0; k < 16; k++) begin : g_row
    tbo_div_cell #(.K(15 - k), .SMALL(1'b0)) u_cell (
      .clk(clk), .rst_n(rst_n), .adv(adv), .d_in(row_c[k]), .d_out(row_c[k+1]));
  end
  // Block row fixup: recompute remainder r = p - by*nx with sy
  tbo_beat_t fx_r, fx_nxt;
  always_comb begin
    fx_nxt = row_c[16];
    fx_nxt.by = {row_c[16].quo[15:2], 2'b00};
    fx_nxt.sy = span(fx_nxt.by, row_c[16].ny);
    fx_nxt.rem = 32'(row_c[16].quo[1:0]) * 32'(row_c[16].nx) + row_c[16].rem;
    fx_nxt.quo = '0;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) fx_r.vld <= 1'b0;
    else if (adv) fx_r <= fx_nxt;
  end
  // Column division: r / sy, quotient below 2^18 (r < 4*nx)
  tbo_beat_t col_c [19];
  assign col_c[0] = fx_r;
  for (genvar k = 0; k < 18; k++) begin : g_col
    tbo_div_cell #(.K(17 - k), .SMALL(1'b1)) u_cell (
      .clk(clk), .rst_n(rst_n), .adv(adv), .d_in(col_c[k]), .d_out(col_c[k+1]));
  end
  // Final stage: split inside the block and register result
  tbo_beat_t cf;
  logic [15:0] bxf;
  logic [2:0] sxf;
  logic [5:0] rr;
  logic [15:0] rx, ry;
  always_comb begin
    cf = col_c[18];
    bxf = {cf.quo[15:2], 2'b00};
    sxf = span(bxf, cf.nx);
    rr = 6'(32'(cf.quo[1:0]) * 32'(cf.sy) + cf.rem);
    ry = 16'd0; rx = 16'd0;
    case (sxf)
      3'd1: begin ry = 16'(rr); rx = 16'd0; end
      3'd2: begin ry = 16'(rr[5:1]); rx = 16'(rr[0]); end
      3'd3: begin
        // Three columns: at most four rows, so compare against multiples of three
        if (rr >= 6'd9) ry = 16'd3;
        else if (rr >= 6'd6) ry = 16'd2;
        else if (rr >= 6'd3) ry = 16'd1;
        else ry = 16'd0;
        rx = 16'(rr - 6'(ry[1:0]) * 6'd3);
      end
      default: begin ry = 16'(rr[5:2]); rx = 16'(rr[1:0]); end
    endcase
    ry = cf.by + ry;
    rx = bxf + rx;
    if (cf.at_end) begin rx = 16'd0; ry = cf.ny; end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (adv) out_valid <= cf.vld;
    if (adv) begin
      out_range_error <= cf.err;
      out_x <= cf.err ? 16'd0 : rx;
      out_y <= cf.err ? 16'd0 : ry;
      out_position <= cf.err ? 32'd0 : cf.p;
    end
  end
endmodule

// ===== rtl/tbo_div_cell.sv =====
// One restoring division step: bit k of quotient, divisor shifted by k
module tbo_div_cell #(
  parameter int K = 0,
  parameter bit SMALL = 1'b0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  tbo_pkg::tbo_beat_t d_in,
  output tbo_pkg::tbo_beat_t d_out
);
  import tbo_pkg::*;
  tbo_beat_t d_r, d_nxt;
  logic [POS_W+18:0] dv;
  always_comb begin
    d_nxt = d_in;
    if (SMALL) dv = {{(POS_W+16){1'b0}}, d_in.sy} << K;
    else       dv = {{(POS_W+3){1'b0}}, d_in.nx} << K;
    if ({{19{1'b0}}, d_in.rem} >= dv) begin
      d_nxt.rem = d_in.rem - dv[POS_W-1:0];
      d_nxt.quo = d_in.quo | (18'd1 << K);
    end
  end
  // Advance the beat
  always_ff @(posedge clk) begin
    if (!rst_n) d_r.vld <= 1'b0;
    else if (adv) d_r.vld <= d_nxt.vld;
    if (adv) begin
      d_r.op <= d_nxt.op; d_r.err <= d_nxt.err; d_r.nx <= d_nxt.nx; d_r.ny <= d_nxt.ny;
      d_r.cx <= d_nxt.cx; d_r.cy <= d_nxt.cy; d_r.p <= d_nxt.p; d_r.rem <= d_nxt.rem;
      d_r.quo <= d_nxt.quo; d_r.by <= d_nxt.by; d_r.bx <= d_nxt.bx; d_r.sy <= d_nxt.sy;
      d_r.sx <= d_nxt.sx; d_r.ly <= d_nxt.ly; d_r.lx <= d_nxt.lx;
      d_r.at_end <= d_nxt.at_end;
    end
  end
  assign d_out = d_r;
endmodule

// ===== rtl/tbo_checker.sv =====
`include "assert_macros.svh"
module tbo_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_x,
  input logic [15:0] out_y,
  input logic [31:0] out_position,
  input logic        out_range_error
);
  `CHK_IMPL(a_err_zero, clk, rst_n, out_valid && out_range_error, out_x == 16'd0 && out_y == 16'd0 && out_position == 32'd0, "error beat carries nonzero fields")
  `CHK_IMPL(a_stall_link, clk, rst_n, out_valid && out_stall, in_stall, "input taken while output blocked")
  `CHK_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_position), "stalled beat changed")
endmodule
bind tiled_2d_block_order_index tbo_checker u_chk (.*);

// ===== dv/tbo_scoreboard.sv =====
`timescale 1ns / 1ps
module tbo_scoreboard (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_coord_x,
  input  logic [15:0] in_coord_y,
  input  logic [31:0] in_position,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_x,
  input  logic [15:0] out_y,
  input  logic [31:0] out_position,
  input  logic        out_range_error,
  output int          fail_count,
  output int          pending
);
  import tbo_pkg::*;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] pos;
    logic        err;
  } mapping_t;

  logic [15:0] width_q, height_q;
  mapping_t    mapping_q[$];

  function automatic longint unsigned extent(input logic [15:0] v);
    longint unsigned e;
    e = v;
    if (e == 0) e = 1;
    return e;
  endfunction

  function automatic longint unsigned min64(input longint unsigned a, input longint unsigned b);
    return (a < b) ? a : b;
  endfunction

  // Linear position of a valid coordinate pair
  function automatic longint unsigned tile_pos(input longint unsigned x, input longint unsigned y,
                                               input longint unsigned nx,
                                               input longint unsigned ny);
    longint unsigned by, bx, sy, sx;
    if (y == ny) return nx * ny;
    by = y & ~64'd3;
    sy = min64(by + 4, ny) - by;
    bx = x & ~64'd3;
    sx = min64(bx + 4, nx) - bx;
    return by * nx + bx * sy + (y - by) * sx + (x - bx);
  endfunction

  function automatic mapping_t map_item(input logic [1:0] op, input logic [15:0] cx,
                                        input logic [15:0] cy, input logic [31:0] pin);
    longint unsigned nx, ny, total, p, by, bx, sy, sx, r;
    logic ok, err;
    mapping_t m;
    nx = extent(width_q);
    ny = extent(height_q);
    total = nx * ny;
    ok = (cy < ny && cx < nx) || (cy == ny && cx == 0);
    err = 1'b0;
    p = 0;
    m = '0;
    if (op == OP_P2C) begin
      if (pin > total) err = 1'b1;
      else p = pin;
    end else if (!ok) begin
      err = 1'b1;
    end else begin
      p = tile_pos(cx, cy, nx, ny);
      if (op == OP_INC) begin
        if (p == total) err = 1'b1;
        else p = p + 1;
      end else if (op == OP_DEC) begin
        if (p == 0) err = 1'b1;
        else p = p - 1;
      end
    end
    if (err) begin
      m.err = 1'b1;
      return m;
    end
    m.pos = p[31:0];
    if (p == total) begin
      m.y = ny[15:0];
      return m;
    end
    by = (p / nx) & ~64'd3;
    sy = min64(by + 4, ny) - by;
    r  = p - by * nx;
    bx = (r / sy) & ~64'd3;
    sx = min64(bx + 4, nx) - bx;
    r  = r - bx * sy;
    m.y = 16'(by + r / sx);
    m.x = 16'(bx + r % sx);
    return m;
  endfunction

  assign pending = mapping_q.size();

  always @(posedge clk) begin
    mapping_t want;
    int       errs;
    errs = 0;
    if (!rst_n) begin
      width_q    <= 16'd1;
      height_q   <= 16'd1;
      fail_count <= 0;
      mapping_q.delete();
    end else begin
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_WIDTH) width_q <= cfg_data;
        else height_q <= cfg_data;
      end
      // Predict each accepted beat
      if (in_valid && !in_stall)
        mapping_q.push_back(map_item(in_operation, in_coord_x, in_coord_y, in_position));
      // Compare each delivered beat
      if (out_valid && !out_stall) begin
        if (mapping_q.size() == 0) begin
          $error("unexpected result beat");
          errs = errs + 1;
        end else begin
          want = mapping_q.pop_front();
          if (out_x !== want.x) begin
            $error("out_x exp %0d got %0d", want.x, out_x);
            errs = errs + 1;
          end
          if (out_y !== want.y) begin
            $error("out_y exp %0d got %0d", want.y, out_y);
            errs = errs + 1;
          end
          if (out_position !== want.pos) begin
            $error("out_position exp %0d got %0d", want.pos, out_position);
            errs = errs + 1;
          end
          if (out_range_error !== want.err) begin
            $error("range_error exp %0d got %0d", want.err, out_range_error);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import tbo_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_WIDTH;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = OP_C2P;
  logic [15:0] in_coord_x = '0;
  logic [15:0] in_coord_y = '0;
  logic [31:0] in_position = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_x, out_y;
  logic [31:0] out_position;
  logic        out_range_error;
  int          fail_count, pending;
  int          cycle_count = 0;
  logic        calm = 1'b0;
  logic [15:0] cur_w = 16'd1, cur_h = 16'd1;

  always #5 clk = ~clk;

  tiled_2d_block_order_index u_dut (.*);

  tbo_scoreboard u_sb (.*);

  // Stall the result side in short bursts, none late in the run
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 5);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // Give up on a hang
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_WIDTH) cur_w = val;
    else cur_h = val;
  endtask

  task automatic send_beat(input logic [1:0] op, input logic [15:0] cx,
                           input logic [15:0] cy, input logic [31:0] p);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_coord_x   <= cx;
    in_coord_y   <= cy;
    in_position  <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Random beat, mostly inside the array
  task automatic random_beat();
    logic [1:0]  op;
    logic [15:0] ex, ey, cx, cy;
    logic [31:0] tot, p;
    ex  = (cur_w == 0) ? 16'd1 : cur_w;
    ey  = (cur_h == 0) ? 16'd1 : cur_h;
    tot = 32'(ex) * 32'(ey);
    op  = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0: begin
        cx = 16'($urandom);
        cy = 16'($urandom);
      end
      1: begin
        cx = 16'd0;
        cy = ey;
      end
      default: begin
        cx = 16'($urandom_range(0, ex - 1));
        cy = 16'($urandom_range(0, ey - 1));
      end
    endcase
    case ($urandom_range(0, 9))
      0: p = $urandom;
      1: p = tot + $urandom_range(0, 1);
      default: p = $urandom_range(0, tot);
    endcase
    send_beat(op, cx, cy, p);
  endtask

  initial begin
    logic [15:0] sizes [0:9];
    sizes = '{16'd0, 16'd1, 16'd5, 16'd65535, 16'd7, 16'd4, 16'd13, 16'd3, 16'd65534, 16'd9};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: default 1x1, then extremes
    send_beat(OP_C2P, 16'd0, 16'd0, 32'd0);
    send_beat(OP_INC, 16'd0, 16'd0, 32'd0);
    send_beat(OP_INC, 16'd0, 16'd1, 32'd0);
    send_beat(OP_DEC, 16'd0, 16'd0, 32'd0);
    send_beat(OP_DEC, 16'd0, 16'd1, 32'd0);
    send_beat(OP_P2C, 16'd0, 16'd0, 32'd1);
    send_beat(OP_P2C, 16'd0, 16'd0, 32'd2);
    send_beat(OP_P2C, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF);
    drain();
    write_reg(CFG_WIDTH, 16'd6);
    write_reg(CFG_HEIGHT, 16'd7);
    send_beat(OP_C2P, 16'd5, 16'd6, 32'd0);
    send_beat(OP_C2P, 16'd6, 16'd0, 32'd0);
    send_beat(OP_C2P, 16'd1, 16'd7, 32'd0);
    send_beat(OP_C2P, 16'd0, 16'd7, 32'd0);
    send_beat(OP_INC, 16'd5, 16'd6, 32'd0);
    send_beat(OP_DEC, 16'd0, 16'd7, 32'd0);
    send_beat(OP_P2C, 16'd0, 16'd0, 32'd41);
    send_beat(OP_P2C, 16'd0, 16'd0, 32'd42);
    send_beat(OP_P2C, 16'd0, 16'd0, 32'd43);
    drain();
    write_reg(CFG_WIDTH, 16'hFFFF);
    write_reg(CFG_HEIGHT, 16'hFFFF);
    send_beat(OP_C2P, 16'hFFFE, 16'hFFFE, 32'd0);
    send_beat(OP_INC, 16'hFFFE, 16'hFFFE, 32'd0);
    send_beat(OP_P2C, 16'd0, 16'd0, 32'd4294836225);
    send_beat(OP_P2C, 16'd0, 16'd0, 32'd4294836224);
    send_beat(OP_C2P, 16'hFFFF, 16'hFFFF, 32'd0);
    drain();

    // Random phases across a spread of sizes
    for (int ph = 0; ph < 11; ph++) begin
      if (ph == 10) calm = 1'b1;
      if (ph == 10) begin
        write_reg(CFG_WIDTH, 16'($urandom));
        write_reg(CFG_HEIGHT, 16'($urandom));
      end else begin
        write_reg(CFG_WIDTH, sizes[ph]);
        write_reg(CFG_HEIGHT, sizes[(ph * 3 + 1) % 10]);
      end
      repeat (50) random_beat();
      drain();
    end

    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
